// File: rtl/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics package
// Shared types and constants for the sorting chain, its controller and the
// mean divider.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int BYTE_W   = 8;
	localparam int TOTAL_W  = 7;
	localparam int STEP_W   = 3;
	localparam logic [BYTE_W-1:0] MIN_RESET = 8'hFF;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_DIVIDE
	} bss_state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		byte_t    sample;
	} cell_ctrl_t;

endpackage

// File: rtl/bss_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics sample channel
// Carries one sample and its end-of-set mark per transaction.
// ----------------------------------------------------------------------------
interface bss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       last_item;

	modport source (output valid, output sample, output last_item, input ready);
	modport sink (input valid, input sample, input last_item, output ready);
endinterface

// File: rtl/bss_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics result channel
// Carries the statistics of one complete data set per transaction.
// ----------------------------------------------------------------------------
interface bss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] mean_value;
	logic [7:0] median_value;
	logic [7:0] maximum_value;
	logic [7:0] minimum_value;
	logic [6:0] item_total;
	logic       overflowed;

	modport source (output valid, output mean_value, output median_value,
		output maximum_value, output minimum_value, output item_total,
		output overflowed, input ready);
	modport sink (input valid, input mean_value, input median_value,
		input maximum_value, input minimum_value, input item_total,
		input overflowed, output ready);
endinterface

// File: rtl/bss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics sorting cell
// One entry of the descending insertion chain. It keeps its value, takes the
// new sample, or takes the value of a neighbour.
// ----------------------------------------------------------------------------
module bss_cell (
	input  logic               clk,
	input  bss_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               prev_ge,
	input  bss_pkg::byte_t     prev_value,
	input  bss_pkg::byte_t     next_value,
	output bss_pkg::byte_t     value,
	output logic               ge
);
	import bss_pkg::*;

	byte_t value_q;

	assign value = value_q;
	assign ge    = occupied && (value_q >= ctrl.sample);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (!ge) begin
					if (prev_ge) begin
						value_q <= ctrl.sample;
					end else begin
						value_q <= prev_value;
					end
				end
			end
			CELL_SHIFT: begin
				value_q <= next_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end
endmodule

// File: rtl/bss_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics mean divider
// Restoring divider that yields one quotient bit per cycle. The quotient of
// a sum of bytes by their count always fits in one byte.
// ----------------------------------------------------------------------------
module bss_divider #(
	parameter int SUM_W = 14,
	parameter int CNT_W = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_W-1:0]     dividend,
	input  logic [CNT_W-1:0]     divisor,
	output logic                 busy,
	output bss_pkg::byte_t       quotient
);
	import bss_pkg::*;

	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	byte_t             quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              fits;

	assign fits     = rem_q >= den_q;
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(BYTE_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= SUM_W'({divisor, {(BYTE_W-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[BYTE_W-2:0], fits};
		end
	end
endmodule

// File: rtl/byte_set_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics
// Keeps the samples of a data set sorted in a chain of cells and reports
// mean, median, maximum, minimum, count and overflow mark after the last sample.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the samples channel, one byte per transaction, with
// last_item marking the final sample of a set. While a set is collected the
// block takes one sample per cycle; each sample is inserted into the
// descending chain in the cycle of its transaction. Samples that arrive when
// MAX_ITEMS are already stored are dropped and the result reports overflowed.
// After the marked sample the chain shifts towards its head until the middle
// entries have been read, and then the mean divider runs, one quotient bit per
// cycle. The result is then registered on the results channel, and the next
// set may start at once. If the receiver stalls, the result waits in its
// register; the next set is collected meanwhile and its result waits until the
// register is free. Reset clears the count, sum, extremes and the result
// valid; the chain itself needs no clearing.
// ----------------------------------------------------------------------------
module byte_set_statistics #(
	parameter int MAX_ITEMS = 64
) (
	input logic       clk,
	input logic       arst_n,
	bss_in_if.sink    samples,
	bss_out_if.source results
);
	import bss_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W = BYTE_W + CNT_W;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);

	bss_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	byte_t            max_q;
	byte_t            min_q;
	logic             drop_q;
	logic [CNT_W-1:0] scan_q;
	byte_t            prev_q;
	byte_t            median_q;

	logic             out_valid_q;
	byte_t            mean_q;
	byte_t            median_out_q;
	byte_t            max_out_q;
	byte_t            min_out_q;
	logic [TOTAL_W-1:0] total_q;
	logic             overflow_q;

	logic             accept;
	logic             store;
	logic             at_mid;
	logic             out_free;
	logic             finish;
	logic             div_start;
	logic             div_busy;
	byte_t            quotient;
	logic [BYTE_W:0]  pair_sum;
	cell_ctrl_t       ctrl;

	byte_t cell_value [MAX_ITEMS];
	logic  cell_ge    [MAX_ITEMS];

	assign accept   = samples.valid && samples.ready;
	assign store    = accept && (count_q != FULL);
	assign at_mid   = scan_q == (count_q >> 1);
	assign out_free = !out_valid_q || results.ready;
	assign pair_sum = {1'b0, prev_q} + {1'b0, cell_value[0]};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (accept && samples.last_item) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (at_mid) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (!div_busy && out_free) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	// Controls.
	always_comb begin
		samples.ready = 1'b0;
		ctrl.op       = CELL_HOLD;
		ctrl.sample   = samples.sample;
		div_start     = 1'b0;
		finish        = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				samples.ready = 1'b1;
				if (store) begin
					ctrl.op = CELL_INSERT;
				end
			end
			ST_SCAN: begin
				if (at_mid) begin
					div_start = 1'b1;
				end else begin
					ctrl.op = CELL_SHIFT;
				end
			end
			ST_DIVIDE: begin
				finish = !div_busy && out_free;
			end
			default: begin
				samples.ready = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic  prev_ge;
		byte_t prev_value;
		byte_t next_value;

		if (i == 0) begin : g_head
			assign prev_ge    = 1'b1;
			assign prev_value = samples.sample;
		end else begin : g_body
			assign prev_ge    = cell_ge[i-1];
			assign prev_value = cell_value[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_value = '0;
		end else begin : g_inner
			assign next_value = cell_value[i+1];
		end

		bss_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (IDX < count_q),
			.prev_ge    (prev_ge),
			.prev_value (prev_value),
			.next_value (next_value),
			.value      (cell_value[i]),
			.ge         (cell_ge[i])
		);
	end

	bss_divider #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			count_q <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= MIN_RESET;
			drop_q  <= 1'b0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				count_q <= '0;
				sum_q   <= '0;
				max_q   <= '0;
				min_q   <= MIN_RESET;
				drop_q  <= 1'b0;
			end else if (store) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(samples.sample);
				if (samples.sample > max_q) begin
					max_q <= samples.sample;
				end
				if (samples.sample < min_q) begin
					min_q <= samples.sample;
				end
			end else if (accept) begin
				drop_q <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end else begin
				scan_q <= '0;
			end
		end
	end

	// The head of the chain holds entry scan_q while the chain drains.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			prev_q <= cell_value[0];
			if (at_mid) begin
				if (count_q[0]) begin
					median_q <= cell_value[0];
				end else begin
					median_q <= pair_sum[BYTE_W:1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			mean_q       <= quotient;
			median_out_q <= median_q;
			max_out_q    <= max_q;
			min_out_q    <= min_q;
			total_q      <= TOTAL_W'(count_q);
			overflow_q   <= drop_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.mean_value    = mean_q;
	assign results.median_value  = median_out_q;
	assign results.maximum_value = max_out_q;
	assign results.minimum_value = min_out_q;
	assign results.item_total    = total_q;
	assign results.overflowed    = overflow_q;
endmodule

// File: test/byte_set_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte set statistics testbench
// Streams data sets of byte samples into the block under a range of sender
// and receiver idling patterns, predicts the mean, median, extremes, count
// and overflow mark of every set from a sorted copy of its samples, and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module byte_set_statistics_tb;
	import bss_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = CAPACITY / 2 + 40;

	typedef struct packed {
		byte_t              mean_value;
		byte_t              median_value;
		byte_t              maximum_value;
		byte_t              minimum_value;
		logic [TOTAL_W-1:0] item_total;
		logic               overflowed;
	} set_stats_t;

	typedef enum int {
		PAT_UNIFORM,
		PAT_NARROW,
		PAT_CONSTANT,
		PAT_EXTREME,
		PAT_RISING,
		PAT_FALLING
	} value_pattern_t;

	logic clk;
	logic arst_n;

	bss_in_if  samples_ch();
	bss_out_if results_ch();

	byte_set_statistics #(
		.MAX_ITEMS(CAPACITY)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	byte_t      sorted_samples [CAPACITY];
	int         stored_total = 0;
	int         sample_sum = 0;
	byte_t      largest = 8'h00;
	byte_t      smallest = 8'hFF;
	logic       dropped = 1'b0;
	set_stats_t expected_stats [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int idle_cycles = 0;
	int error_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_set_stats();
		stored_total = 0;
		sample_sum = 0;
		largest = 8'h00;
		smallest = 8'hFF;
		dropped = 1'b0;
	endfunction

	function automatic void absorb_sample(byte_t s, logic lst);
		int pos;
		int pair;
		set_stats_t st;
		if (stored_total < CAPACITY) begin
			pos = stored_total;
			while (pos > 0 && sorted_samples[pos - 1] < s) begin
				sorted_samples[pos] = sorted_samples[pos - 1];
				pos--;
			end
			sorted_samples[pos] = s;
			stored_total++;
			sample_sum += s;
			if (s > largest)
				largest = s;
			if (s < smallest)
				smallest = s;
		end else begin
			dropped = 1'b1;
		end
		if (lst) begin
			st.mean_value = byte_t'(sample_sum / stored_total);
			if (stored_total % 2 == 0) begin
				pair = sorted_samples[stored_total / 2 - 1] + sorted_samples[stored_total / 2];
				st.median_value = byte_t'(pair / 2);
			end else begin
				st.median_value = sorted_samples[stored_total / 2];
			end
			st.maximum_value = largest;
			st.minimum_value = smallest;
			st.item_total = stored_total[TOTAL_W-1:0];
			st.overflowed = dropped;
			expected_stats.push_back(st);
			clear_set_stats();
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_sample(input byte_t s, input logic lst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.sample <= s;
		samples_ch.last_item <= lst;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		absorb_sample(s, lst);
	endtask

	task automatic send_set(input byte_t vals [$]);
		foreach (vals[i])
			send_sample(vals[i], i == vals.size() - 1);
	endtask

	task automatic wait_drained();
		samples_ch.valid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	function automatic byte_t pattern_value(value_pattern_t pat, int base, int idx);
		case (pat)
			PAT_NARROW:   return byte_t'((base & 'hF8) | $urandom_range(0, 7));
			PAT_CONSTANT: return byte_t'(base);
			PAT_EXTREME:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			PAT_RISING:   return byte_t'((base + idx > 255) ? 255 : base + idx);
			PAT_FALLING:  return byte_t'((base - idx < 0) ? 0 : base - idx);
			default:      return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int random_set_size();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 8);
		if (pick < 90)
			return $urandom_range(9, 40);
		if (pick < 97)
			return $urandom_range(41, CAPACITY);
		return $urandom_range(CAPACITY + 1, CAPACITY + 8);
	endfunction

	task automatic test_directed_sets();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_set('{8'd0});
		send_set('{8'd255});
		send_set('{8'd255, 8'd255});
		send_set('{8'd0, 8'd255});
		send_set('{8'd1, 8'd2});
		send_set('{8'd3, 8'd1, 8'd2});
		send_set('{8'd10, 8'd10, 8'd10, 8'd10});
		send_set('{8'd1, 8'd2, 8'd3, 8'd4, 8'd5});
		send_set('{8'd200, 8'd150, 8'd100, 8'd50});
		wait_drained();
	endtask

	task automatic test_store_full();
		int sizes [4];
		byte_t v;
		sizes = '{CAPACITY, CAPACITY + 1, CAPACITY + 6, CAPACITY + 2};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (sizes[k]) begin
			for (int i = 0; i < sizes[k]; i++) begin
				if (i < CAPACITY)
					v = byte_t'($urandom_range(1, 254));
				else
					v = (i % 2 == 1) ? 8'hFF : 8'h00;
				send_sample(v, i == sizes[k] - 1);
			end
		end
		send_set('{8'd7, 8'd9, 8'd8});
		wait_drained();
	endtask

	task automatic test_random_sets(input int item_goal, input int idle_pct,
		input int stall_pct);
		int sent;
		int n;
		int base;
		value_pattern_t pat;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < item_goal) begin
			n = random_set_size();
			pat = value_pattern_t'($urandom_range(0, PAT_FALLING));
			base = $urandom_range(0, 255);
			for (int i = 0; i < n; i++)
				send_sample(pattern_value(pat, base, i), i == n - 1);
			sent += n;
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 300;
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 5; i++)
				send_sample(byte_t'($urandom_range(0, 255)), i == 4);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			results_ch.ready <= 1'b0;
			hold_cycles--;
		end else begin
			results_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		set_stats_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected result, item_total", results_ch.item_total, 0);
			end else begin
				want = expected_stats.pop_front();
				if (results_ch.mean_value !== want.mean_value)
					report_mismatch("mean_value", results_ch.mean_value, want.mean_value);
				if (results_ch.median_value !== want.median_value)
					report_mismatch("median_value", results_ch.median_value,
						want.median_value);
				if (results_ch.maximum_value !== want.maximum_value)
					report_mismatch("maximum_value", results_ch.maximum_value,
						want.maximum_value);
				if (results_ch.minimum_value !== want.minimum_value)
					report_mismatch("minimum_value", results_ch.minimum_value,
						want.minimum_value);
				if (results_ch.item_total !== want.item_total)
					report_mismatch("item_total", results_ch.item_total, want.item_total);
				if (results_ch.overflowed !== want.overflowed)
					report_mismatch("overflowed", results_ch.overflowed, want.overflowed);
			end
		end
	end

	// The run is abandoned if no transaction completes on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (samples_ch.valid && samples_ch.ready)
			|| (results_ch.valid && results_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.sample = '0;
		samples_ch.last_item = 1'b0;
		results_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_sets();
		test_store_full();
		test_random_sets(220, 0, 0);
		test_random_sets(220, 74, 0);
		test_random_sets(220, 0, 74);
		test_random_sets(220, 23, 23);
		test_backpressure();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_stats.size() != 0) begin
			$display("%0d expected results never arrived", expected_stats.size());
			error_count += expected_stats.size();
		end
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/bss_pkg.sv
rtl/bss_in_if.sv
rtl/bss_out_if.sv
rtl/bss_cell.sv
rtl/bss_divider.sv
rtl/byte_set_statistics.sv
test/byte_set_statistics_tb.sv
